// File: sv/csvtok_pkg.sv
package csvtok_pkg;

  localparam int DEF_MAX_TOKEN_SLOTS = 32;
  localparam int DEF_LINE_LIMIT      = 1024;
  localparam int DEF_SPACE_DEPTH     = 16;

  localparam int MAX_RESULTS     = 17;
  localparam int QUEUE_DEPTH     = 2;
  localparam int SPACE_CNT_W     = 9;
  localparam int SPACE_ADDR_W    = 8;
  localparam int TOKEN_OUT_W     = 5;
  localparam int RESULT_CNT_W    = 5;
  localparam int OUT_DATA_W      = 24;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_HASH      = 8'h23;

  typedef enum logic [1:0] {
    MODE_GAP,
    MODE_FIELD,
    MODE_DONE
  } mode_t;

  // One request for the back end: buffered spaces, then up to two characters.
  typedef struct packed {
    logic [SPACE_CNT_W-1:0] nsp;
    logic [1:0]             nch;
    logic [7:0]             c1;
    logic [7:0]             c2;
    logic                   close;
    logic                   line_end;
    logic [TOKEN_OUT_W-1:0] tok_index;
    logic [TOKEN_OUT_W-1:0] tok_count;
    logic                   err;
  } job_t;

  typedef struct packed {
    logic                    en;
    logic [SPACE_ADDR_W-1:0] addr;
    logic [7:0]              data;
  } spbuf_wr_t;

endpackage

// File: sv/csvtok_front.sv
module csvtok_front #(
  parameter int MAX_TOKEN_SLOTS = csvtok_pkg::DEF_MAX_TOKEN_SLOTS,
  parameter int LINE_LIMIT      = csvtok_pkg::DEF_LINE_LIMIT,
  parameter int SPACE_DEPTH     = csvtok_pkg::DEF_SPACE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tlast,
  input  logic                  q_full,
  output logic                  push,
  output csvtok_pkg::job_t      push_job,
  output csvtok_pkg::spbuf_wr_t buf_wr,
  input  logic                  flush_done
);

  localparam int TK_W = $clog2(MAX_TOKEN_SLOTS);
  localparam int SC_W = $clog2(SPACE_DEPTH + 1);
  localparam int LL_W = $clog2(LINE_LIMIT + 2);

  csvtok_pkg::mode_t mode, mode_next;
  logic              held, held_next;
  logic [SC_W-1:0]   sc, sc_next;
  logic [TK_W-1:0]   tokens, tokens_next;
  logic              seen, seen_next;
  logic [LL_W-1:0]   line_length, line_length_next;
  logic              err_seen, err_seen_next;
  logic              pend, pend_next;

  function automatic logic is_white(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  assign s_tready = !q_full && !pend;

  always_comb begin
    logic              accept;
    logic [7:0]        c;
    logic [LL_W-1:0]   len_v;
    csvtok_pkg::mode_t mode_v;
    logic              held_v;
    logic [SC_W-1:0]   sc_v;
    logic [TK_W:0]     tok_v;
    logic              seen_v;
    logic              err_v;
    logic [1:0]        nch;
    logic              done_byte;
    logic              has_results;

    accept    = s_tvalid && s_tready;
    c         = s_tdata;
    push_job  = '0;
    push_job.tok_index = csvtok_pkg::TOKEN_OUT_W'(tokens);
    buf_wr    = '0;
    nch       = 2'd0;
    done_byte = 1'b0;
    mode_v    = mode;
    held_v    = held;
    sc_v      = sc;
    tok_v     = {1'b0, tokens};
    seen_v    = seen;
    err_v     = err_seen;

    len_v = line_length;
    if (len_v <= LL_W'(LINE_LIMIT)) begin
      len_v = len_v + 1'b1;
    end

    if (len_v > LL_W'(LINE_LIMIT)) begin
      if (mode != csvtok_pkg::MODE_DONE) begin
        err_v  = 1'b1;
        mode_v = csvtok_pkg::MODE_DONE;
        held_v = 1'b0;
        sc_v   = '0;
      end
    end else begin
      unique case (mode)
        csvtok_pkg::MODE_GAP: begin
          priority if (is_white(c)) begin
            seen_v = 1'b1;
          end else if (c == csvtok_pkg::CH_COMMA) begin
            if (seen) begin
              mode_v = csvtok_pkg::MODE_DONE;
            end
          end else if (c == csvtok_pkg::CH_HASH) begin
            mode_v = csvtok_pkg::MODE_DONE;
          end else begin
            mode_v = csvtok_pkg::MODE_FIELD;
            sc_v   = '0;
            if (c == csvtok_pkg::CH_BACKSLASH) begin
              held_v = 1'b1;
            end else begin
              push_job.c1 = c;
              nch = 2'd1;
            end
          end
        end
        csvtok_pkg::MODE_FIELD: begin
          if (held_v) begin
            held_v = 1'b0;
            nch    = 2'd1;
            if (c == csvtok_pkg::CH_COMMA) begin
              push_job.c1 = csvtok_pkg::CH_COMMA;
              done_byte   = 1'b1;
            end else begin
              push_job.c1 = csvtok_pkg::CH_BACKSLASH;
            end
          end
          if (!done_byte) begin
            priority if (c == csvtok_pkg::CH_BACKSLASH) begin
              push_job.nsp = csvtok_pkg::SPACE_CNT_W'(sc_v);
              sc_v   = '0;
              held_v = 1'b1;
            end else if (c == csvtok_pkg::CH_COMMA) begin
              push_job.close = 1'b1;
              tok_v  = tok_v + 1'b1;
              sc_v   = '0;
              seen_v = 1'b0;
              mode_v = (tok_v >= (TK_W+1)'(MAX_TOKEN_SLOTS - 1)) ?
                       csvtok_pkg::MODE_DONE : csvtok_pkg::MODE_GAP;
            end else if (is_white(c)) begin
              if (sc_v < SC_W'(SPACE_DEPTH)) begin
                buf_wr.en   = 1'b1;
                buf_wr.addr = csvtok_pkg::SPACE_ADDR_W'(sc_v);
                buf_wr.data = c;
                sc_v = sc_v + 1'b1;
              end else begin
                err_v = 1'b1;
              end
            end else begin
              push_job.nsp = csvtok_pkg::SPACE_CNT_W'(sc_v);
              sc_v = '0;
              if (nch == 2'd0) begin
                push_job.c1 = c;
              end else begin
                push_job.c2 = c;
              end
              nch = nch + 2'd1;
            end
          end
        end
        csvtok_pkg::MODE_DONE: begin
        end
        default: begin
        end
      endcase
    end

    if (s_tlast) begin
      if (mode_v == csvtok_pkg::MODE_FIELD) begin
        if (held_v) begin
          held_v = 1'b0;
          if (nch == 2'd0) begin
            push_job.c1 = csvtok_pkg::CH_BACKSLASH;
          end else begin
            push_job.c2 = csvtok_pkg::CH_BACKSLASH;
          end
          nch = nch + 2'd1;
        end
        push_job.close = 1'b1;
        tok_v = tok_v + 1'b1;
      end
      push_job.line_end  = 1'b1;
      push_job.tok_count = csvtok_pkg::TOKEN_OUT_W'(tok_v);
      push_job.err       = err_v;
      mode_v = csvtok_pkg::MODE_GAP;
      held_v = 1'b0;
      sc_v   = '0;
      tok_v  = '0;
      seen_v = 1'b0;
      len_v  = '0;
      err_v  = 1'b0;
    end
    push_job.nch = nch;

    has_results = (nch != 2'd0) || (push_job.nsp != '0) || push_job.close ||
                  push_job.line_end;
    push      = accept && has_results;
    buf_wr.en = buf_wr.en && accept;

    mode_next        = mode;
    held_next        = held;
    sc_next          = sc;
    tokens_next      = tokens;
    seen_next        = seen;
    line_length_next = line_length;
    err_seen_next    = err_seen;
    if (accept) begin
      mode_next        = mode_v;
      held_next        = held_v;
      sc_next          = sc_v;
      tokens_next      = tok_v[TK_W-1:0];
      seen_next        = seen_v;
      line_length_next = len_v;
      err_seen_next    = err_v;
    end

    pend_next = pend;
    if (flush_done) begin
      pend_next = 1'b0;
    end
    if (push && push_job.nsp != '0) begin
      pend_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= csvtok_pkg::MODE_GAP;
      held        <= 1'b0;
      sc          <= '0;
      tokens      <= '0;
      seen        <= 1'b0;
      line_length <= '0;
      err_seen    <= 1'b0;
      pend        <= 1'b0;
    end else begin
      mode        <= mode_next;
      held        <= held_next;
      sc          <= sc_next;
      tokens      <= tokens_next;
      seen        <= seen_next;
      line_length <= line_length_next;
      err_seen    <= err_seen_next;
      pend        <= pend_next;
    end
  end

endmodule

// File: sv/csvtok_queue.sv
module csvtok_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  csvtok_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output csvtok_pkg::job_t pop_job
);

  localparam int QP_W = (csvtok_pkg::QUEUE_DEPTH > 1) ? $clog2(csvtok_pkg::QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(csvtok_pkg::QUEUE_DEPTH + 1);

  csvtok_pkg::job_t entries [csvtok_pkg::QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr, rd_ptr;
  logic [QC_W-1:0]  count;
  logic             do_push, do_pop;

  assign full      = count == QC_W'(csvtok_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QP_W'(csvtok_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(csvtok_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/csvtok_back.sv
module csvtok_back #(
  parameter int SPACE_DEPTH = csvtok_pkg::DEF_SPACE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  csvtok_pkg::job_t                     q_job,
  input  csvtok_pkg::spbuf_wr_t                buf_wr,
  output logic                                 flush_done,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [csvtok_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  localparam int SA_W = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int RC_W = csvtok_pkg::RESULT_CNT_W;
  localparam int SN_W = csvtok_pkg::SPACE_CNT_W;
  localparam int TO_W = csvtok_pkg::TOKEN_OUT_W;

  logic [7:0] spbuf [SPACE_DEPTH];
  logic [7:0] rd_data;

  logic             job_valid;
  csvtok_pkg::job_t job;
  logic [RC_W-1:0]  kept, n, k;

  logic             s1_valid;
  logic             s1_space, s1_tend, s1_le, s1_err, s1_last, s1_has;
  logic [7:0]       s1_ch;
  logic [TO_W-1:0]  s1_idx, s1_cnt;

  logic             o_has, o_tend, o_le, o_err, o_last;
  logic [7:0]       o_ch;
  logic [TO_W-1:0]  o_idx, o_cnt;

  logic             out_free, s1_move, s1_free, gen_fire, gen_last;
  logic [SN_W:0]    sum;
  logic [RC_W-1:0]  kept_new, n_new;
  logic             g_space, g_has, g_first;

  always_comb begin
    out_free   = !m_tvalid || m_tready;
    s1_move    = s1_valid && out_free;
    s1_free    = !s1_valid || s1_move;
    gen_fire   = job_valid && s1_free;
    gen_last   = k == (n - 1'b1);
    q_pop      = q_valid && (!job_valid || (gen_fire && gen_last));
    flush_done = gen_fire && gen_last && (job.nsp != '0);

    sum      = {1'b0, q_job.nsp} + (SN_W+1)'(q_job.nch);
    kept_new = (sum > (SN_W+1)'(csvtok_pkg::MAX_RESULTS)) ?
               RC_W'(csvtok_pkg::MAX_RESULTS) : sum[RC_W-1:0];
    n_new    = (kept_new != '0) ? kept_new : RC_W'(1);

    g_space = SN_W'(k) < job.nsp;
    g_has   = k < kept;
    g_first = SN_W'(k) == job.nsp;
  end

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      spbuf[buf_wr.addr[SA_W-1:0]] <= buf_wr.data;
    end
    if (gen_fire && g_space) begin
      rd_data <= spbuf[SA_W'(k)];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job  <= q_job;
      kept <= kept_new;
      n    <= n_new;
      k    <= '0;
    end else if (gen_fire) begin
      k <= k + 1'b1;
    end
    if (gen_fire) begin
      s1_space <= g_space;
      s1_has   <= g_has;
      s1_ch    <= g_has ? (g_first ? job.c1 : job.c2) : 8'h00;
      s1_tend  <= gen_last && job.close;
      s1_le    <= gen_last && job.line_end;
      s1_cnt   <= (gen_last && job.line_end) ? job.tok_count : '0;
      s1_err   <= gen_last && job.line_end && job.err;
      s1_last  <= gen_last;
      s1_idx   <= job.tok_index;
    end
    if (s1_move) begin
      o_has  <= s1_has;
      o_ch   <= s1_space ? rd_data : s1_ch;
      o_idx  <= s1_idx;
      o_tend <= s1_tend;
      o_le   <= s1_le;
      o_cnt  <= s1_cnt;
      o_err  <= s1_err;
      o_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      s1_valid  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid <= 1'b1;
      end else if (gen_fire && gen_last) begin
        job_valid <= 1'b0;
      end
      if (gen_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {3'b000, o_last, o_err, o_cnt, o_tend, o_idx, o_ch};
  assign m_tuser = o_has;
  assign m_tlast = o_le;

endmodule

// File: sv/csv_line_tokenizer_unit.sv
// Comma-separated line tokenizer.
// The input stream carries one byte of a line per request in s_tdata, with
// s_tlast on the final byte of the line. The output stream carries one result
// per request: m_tuser says m_tdata holds a token character, and m_tlast marks
// the last result of a line, which also carries the token count and error flag.
// A front end classifies each byte, keeps the per-line state and writes trailing
// whitespace into a small buffer; a two-entry queue hands its work to a back end
// that produces the results from that buffer and the queued bytes, one per
// cycle while the receiver accepts them. A byte is accepted every cycle while
// the queue has room. A byte that releases buffered whitespace blocks input
// until the back end has produced the last result of that byte.
// A byte's results pass from the queue through the job register and the s1
// stage to the output register.
// When the receiver stalls, the output register and the stage behind it hold,
// the queue fills, and s_tready drops; nothing is lost.
// Reset clears all line state and the queue; the whitespace buffer is not
// cleared, and only entries written in the current field are read.
module csv_line_tokenizer_unit #(
  parameter int MAX_TOKEN_SLOTS = csvtok_pkg::DEF_MAX_TOKEN_SLOTS,
  parameter int LINE_LIMIT      = csvtok_pkg::DEF_LINE_LIMIT,
  parameter int SPACE_DEPTH     = csvtok_pkg::DEF_SPACE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // in_char
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_char[7:0], token_index[12:8], token_end[13], token_count[18:14],
  // error_flag[19], last_result[20], zero[23:21]
  output logic [csvtok_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                              m_tuser,   // has_char
  output logic                              m_tlast
);

  logic                  q_full, push, q_valid, q_pop, flush_done;
  csvtok_pkg::job_t      push_job, q_job;
  csvtok_pkg::spbuf_wr_t buf_wr;

  csvtok_front #(
    .MAX_TOKEN_SLOTS(MAX_TOKEN_SLOTS),
    .LINE_LIMIT(LINE_LIMIT),
    .SPACE_DEPTH(SPACE_DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .q_full(q_full),
    .push(push),
    .push_job(push_job),
    .buf_wr(buf_wr),
    .flush_done(flush_done)
  );

  csvtok_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .full(q_full),
    .pop(q_pop),
    .pop_valid(q_valid),
    .pop_job(q_job)
  );

  csvtok_back #(
    .SPACE_DEPTH(SPACE_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .q_job(q_job),
    .buf_wr(buf_wr),
    .flush_done(flush_done),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

endmodule

// File: test/csv_line_tokenizer_unit_tb.sv
`timescale 1ns / 100ps

module csv_line_tokenizer_unit_tb;
  import csvtok_pkg::*;

  localparam int TOKEN_SLOTS = DEF_MAX_TOKEN_SLOTS;
  localparam int LINE_MAX = DEF_LINE_LIMIT;
  localparam int SPACE_SLOTS = DEF_SPACE_DEPTH;
  localparam int RANDOM_ITEMS = 440;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef struct packed {
    logic                   has_char;
    logic [7:0]             out_char;
    logic [TOKEN_OUT_W-1:0] token_index;
    logic                   token_end;
    logic                   line_end;
    logic [TOKEN_OUT_W-1:0] token_count;
    logic                   error_flag;
    logic                   last_result;
  } tok_result_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eol;
    logic        typed;
    tok_result_t res;
  } stim_row_t;

  localparam tok_result_t R_NONE = '0;
  localparam tok_result_t R_EMPTY_LINE = '{1'b0, 8'h00, 5'd0, 1'b0, 1'b1, 5'd0, 1'b0, 1'b1};

  localparam stim_row_t DIR_TAB [24] = '{
    '{8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 5'd0, 1'b1, 1'b1, 5'd1, 1'b0, 1'b1}},
    '{8'h00, 1'b1, 1'b1, '{1'b1, 8'h00, 5'd0, 1'b1, 1'b1, 5'd1, 1'b0, 1'b1}},
    '{CH_HASH, 1'b1, 1'b1, R_EMPTY_LINE},
    '{CH_COMMA, 1'b1, 1'b1, R_EMPTY_LINE},
    '{CH_SPACE, 1'b1, 1'b1, R_EMPTY_LINE},
    '{CH_SPACE, 1'b0, 1'b0, R_NONE},
    '{"a", 1'b0, 1'b0, R_NONE},
    '{CH_SPACE, 1'b0, 1'b0, R_NONE},
    '{CH_SEMI, 1'b0, 1'b0, R_NONE},
    '{CH_BACKSLASH, 1'b0, 1'b0, R_NONE},
    '{CH_COMMA, 1'b0, 1'b0, R_NONE},
    '{"b", 1'b0, 1'b0, R_NONE},
    '{CH_TAB, 1'b0, 1'b0, R_NONE},
    '{CH_COMMA, 1'b0, 1'b0, R_NONE},
    '{CH_COMMA, 1'b0, 1'b0, R_NONE},
    '{"c", 1'b0, 1'b0, R_NONE},
    '{CH_SPACE, 1'b1, 1'b0, R_NONE},
    '{"x", 1'b0, 1'b0, R_NONE},
    '{CH_COMMA, 1'b0, 1'b0, R_NONE},
    '{CH_CR, 1'b0, 1'b0, R_NONE},
    '{CH_COMMA, 1'b0, 1'b0, R_NONE},
    '{"y", 1'b1, 1'b0, R_NONE},
    '{"p", 1'b0, 1'b0, R_NONE},
    '{CH_BACKSLASH, 1'b1, 1'b0, R_NONE}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  logic        row_typed = 1'b0;
  tok_result_t row_expect = '0;

  mode_t      pmode;
  bit         held_bs;
  logic [7:0] space_buf [SPACE_SLOTS];
  int         space_cnt;
  int         tokens_done;
  bit         seen_white;
  int         line_len;
  bit         err_seen;

  tok_result_t byte_results[$];
  tok_result_t token_stream_q[$];
  logic [7:0]  line_bytes[$];

  int mismatch_count = 0;
  int sent_items = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  bit sink_open = 1'b0;

  csv_line_tokenizer_unit #(
    .MAX_TOKEN_SLOTS(TOKEN_SLOTS),
    .LINE_LIMIT(LINE_MAX),
    .SPACE_DEPTH(SPACE_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit is_white(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic void clear_line();
    pmode = MODE_GAP;
    held_bs = 1'b0;
    space_cnt = 0;
    tokens_done = 0;
    seen_white = 1'b0;
    line_len = 0;
    err_seen = 1'b0;
  endfunction

  function automatic void push_result(bit has, logic [7:0] ch, bit tend);
    tok_result_t r;
    if (byte_results.size() >= MAX_RESULTS) return;
    r = '0;
    r.has_char = has;
    r.out_char = ch;
    r.token_index = tokens_done[TOKEN_OUT_W-1:0];
    r.token_end = tend;
    byte_results.push_back(r);
  endfunction

  function automatic void flush_spaces();
    for (int i = 0; i < space_cnt && i < SPACE_SLOTS; i++) begin
      push_result(1'b1, space_buf[i], 1'b0);
    end
    space_cnt = 0;
  endfunction

  function automatic void field_char(logic [7:0] c);
    flush_spaces();
    push_result(1'b1, c, 1'b0);
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    if (pmode == MODE_GAP) begin
      if (is_white(c)) begin
        seen_white = 1'b1;
      end else if (c == CH_COMMA) begin
        if (seen_white) pmode = MODE_DONE;
      end else if (c == CH_HASH) begin
        pmode = MODE_DONE;
      end else begin
        pmode = MODE_FIELD;
        space_cnt = 0;
        if (c == CH_BACKSLASH) held_bs = 1'b1;
        else push_result(1'b1, c, 1'b0);
      end
      return;
    end
    if (pmode != MODE_FIELD) return;
    if (held_bs) begin
      held_bs = 1'b0;
      if (c == CH_COMMA) begin
        field_char(CH_COMMA);
        return;
      end
      field_char(CH_BACKSLASH);
    end
    if (c == CH_BACKSLASH) begin
      flush_spaces();
      held_bs = 1'b1;
    end else if (c == CH_COMMA) begin
      push_result(1'b0, 8'h00, 1'b1);
      tokens_done++;
      space_cnt = 0;
      seen_white = 1'b0;
      pmode = (tokens_done >= TOKEN_SLOTS - 1) ? MODE_DONE : MODE_GAP;
    end else if (is_white(c)) begin
      if (space_cnt < SPACE_SLOTS) begin
        space_buf[space_cnt] = c;
        space_cnt++;
      end else begin
        err_seen = 1'b1;
      end
    end else begin
      field_char(c);
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, bit eol);
    tok_result_t r;
    int last;
    byte_results.delete();
    if (line_len <= LINE_MAX) line_len++;
    if (line_len > LINE_MAX) begin
      if (pmode != MODE_DONE) begin
        err_seen = 1'b1;
        pmode = MODE_DONE;
        held_bs = 1'b0;
        space_cnt = 0;
      end
    end else begin
      scan_byte(c);
    end
    if (eol) begin
      if (pmode == MODE_FIELD) begin
        if (held_bs) begin
          held_bs = 1'b0;
          field_char(CH_BACKSLASH);
        end
        last = byte_results.size() - 1;
        if (last >= 0 && byte_results[last].has_char) begin
          r = byte_results[last];
          r.token_end = 1'b1;
          byte_results[last] = r;
        end else begin
          push_result(1'b0, 8'h00, 1'b1);
        end
        tokens_done++;
      end
      if (byte_results.size() == 0) push_result(1'b0, 8'h00, 1'b0);
      last = byte_results.size() - 1;
      r = byte_results[last];
      r.line_end = 1'b1;
      r.token_count = tokens_done[TOKEN_OUT_W-1:0];
      r.error_flag = err_seen;
      byte_results[last] = r;
      clear_line();
    end
    if (byte_results.size() > 0) begin
      last = byte_results.size() - 1;
      r = byte_results[last];
      r.last_result = 1'b1;
      byte_results[last] = r;
    end
  endfunction

  initial clear_line();

  always @(posedge clk) begin : monitor
    tok_result_t got;
    tok_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sent_items++;
        tokenize_byte(s_tdata, s_tlast);
        if (row_typed) token_stream_q.push_back(row_expect);
        else foreach (byte_results[i]) token_stream_q.push_back(byte_results[i]);
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tuser, m_tdata[7:0], m_tdata[12:8], m_tdata[13], m_tlast,
                m_tdata[18:14], m_tdata[19], m_tdata[20]};
        if (token_stream_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"unexpected result: has=%0d ch=%02h idx=%0d tend=%0d",
                      " lend=%0d cnt=%0d err=%0d last=%0d"},
                     got.has_char, got.out_char, got.token_index, got.token_end,
                     got.line_end, got.token_count, got.error_flag, got.last_result);
        end else begin
          want = token_stream_q.pop_front();
          if (got.has_char !== want.has_char || got.out_char !== want.out_char ||
              got.token_index !== want.token_index || got.token_end !== want.token_end ||
              got.line_end !== want.line_end || got.token_count !== want.token_count ||
              got.error_flag !== want.error_flag || got.last_result !== want.last_result) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display({"mismatch: expected has=%0d ch=%02h idx=%0d tend=%0d",
                        " lend=%0d cnt=%0d err=%0d last=%0d"},
                       want.has_char, want.out_char, want.token_index, want.token_end,
                       want.line_end, want.token_count, want.error_flag, want.last_result);
              $display({"          actual   has=%0d ch=%02h idx=%0d tend=%0d",
                        " lend=%0d cnt=%0d err=%0d last=%0d"},
                       got.has_char, got.out_char, got.token_index, got.token_end,
                       got.line_end, got.token_count, got.error_flag, got.last_result);
            end
          end
        end
      end
    end
  end

  initial begin : sink
    int hold_left;
    int phase_left;
    int phase_kind;
    hold_left = 0;
    phase_left = 0;
    phase_kind = 0;
    forever begin
      @(posedge clk);
      if (sink_open) begin
        m_tready <= 1'b1;
      end else if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_kind = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        case (phase_kind)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= (phase_left[1:0] == 2'd0);
          default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input bit eol, input bit typed,
                           input tok_result_t tr);
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= eol;
    row_typed <= typed;
    row_expect <= tr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic idle_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (token_stream_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_bytes[i])
      send_byte(line_bytes[i], i == line_bytes.size() - 1, 1'b0, R_NONE);
  endtask

  function automatic logic [7:0] pick_white();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_white(c) || c == CH_COMMA || c == CH_BACKSLASH);
    return c;
  endfunction

  function automatic void build_field(bit is_last);
    repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_white());
    if ($urandom_range(0, 19) == 0) line_bytes.push_back(CH_HASH);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          repeat ($urandom_range(1, 3)) line_bytes.push_back(pick_white());
          line_bytes.push_back(pick_plain());
        end
        2: begin
          line_bytes.push_back(CH_BACKSLASH);
          line_bytes.push_back(CH_COMMA);
        end
        3: begin
          line_bytes.push_back(CH_BACKSLASH);
          line_bytes.push_back(pick_plain());
        end
        4: line_bytes.push_back(CH_SEMI);
        default: line_bytes.push_back(pick_plain());
      endcase
    end
    case ($urandom_range(0, 19))
      0: begin
        repeat ($urandom_range(SPACE_SLOTS + 1, SPACE_SLOTS + 4))
          line_bytes.push_back(pick_white());
        if ($urandom_range(0, 1) == 1) line_bytes.push_back(pick_plain());
      end
      1, 2, 3, 4, 5: repeat ($urandom_range(1, 3)) line_bytes.push_back(pick_white());
      default: ;
    endcase
    if (!is_last) begin
      line_bytes.push_back(CH_COMMA);
      if ($urandom_range(0, 7) == 0) line_bytes.push_back(CH_COMMA);
    end else if ($urandom_range(0, 7) == 0) begin
      line_bytes.push_back(CH_BACKSLASH);
    end
  endfunction

  function automatic void build_line();
    int kind;
    int nf;
    int blank;
    int pos;
    line_bytes.delete();
    kind = $urandom_range(0, 19);
    if (kind < 13) begin
      nf = $urandom_range(1, 5);
      for (int f = 0; f < nf; f++) build_field(f == nf - 1);
    end else if (kind < 16) begin
      repeat ($urandom_range(1, 15)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 19) begin
      nf = $urandom_range(2, 4);
      blank = $urandom_range(0, nf - 1);
      for (int f = 0; f < nf; f++) begin
        if (f == blank) begin
          repeat ($urandom_range(1, 3)) line_bytes.push_back(pick_white());
          line_bytes.push_back(CH_COMMA);
        end else begin
          build_field(f == nf - 1);
        end
      end
      pos = $urandom_range(0, line_bytes.size() - 1);
      line_bytes[pos] = 8'($urandom_range(0, 255));
    end else begin
      repeat (TOKEN_SLOTS + 1) begin
        line_bytes.push_back(pick_plain());
        line_bytes.push_back(CH_COMMA);
      end
    end
  endfunction

  initial begin : stimulus
    int base;
    int guard;
    bit hold_done;
    bit drain_done;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_TAB[i])
      send_byte(DIR_TAB[i].ch, DIR_TAB[i].eol, DIR_TAB[i].typed, DIR_TAB[i].res);
    idle_until_drained();

    base = sent_items;
    hold_done = 1'b0;
    drain_done = 1'b0;
    while (sent_items - base < RANDOM_ITEMS) begin
      build_line();
      send_line();
      if (!hold_done && sent_items - base > RANDOM_ITEMS / 3) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent_items - base > (2 * RANDOM_ITEMS) / 3) begin
        idle_until_drained();
        drain_done = 1'b1;
      end
    end

    s_tvalid <= 1'b0;
    sink_open = 1'b1;
    guard = 0;
    while (token_stream_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && token_stream_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
